// File: design/jsu_pkg.sv
// shared types and constants for the json string unescaper
package jsu_pkg;

  // parser modes of the front part
  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_ESC     = 4'd1,
    MODE_HEX1    = 4'd2,
    MODE_HEX2    = 4'd3,
    MODE_HEX3    = 4'd4,
    MODE_HEX4    = 4'd5,
    MODE_PAIR_BS = 4'd6,
    MODE_PAIR_U  = 4'd7,
    MODE_LOW1    = 4'd8,
    MODE_LOW2    = 4'd9,
    MODE_LOW3    = 4'd10,
    MODE_LOW4    = 4'd11
  } mode_e;

  // result outcome codes
  localparam logic [2:0] OUT_BYTE     = 3'd0;
  localparam logic [2:0] OUT_DONE     = 3'd1;
  localparam logic [2:0] OUT_BAD_ESC  = 3'd2;
  localparam logic [2:0] OUT_BAD_HEX  = 3'd3;
  localparam logic [2:0] OUT_BAD_SURR = 3'd4;
  localparam logic [2:0] OUT_END      = 3'd5;

  localparam int unsigned CpWidth = 21;

  // one classified item as handed from front to back
  typedef struct packed {
    logic               is_cp;    // value is a code point to encode as utf-8
    logic [CpWidth-1:0] value;    // code point, or raw byte in the low bits
    logic [2:0]         outcome;
  } action_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: design/json_string_unescape.sv
// json string unescaper top level: front parser, action queue, utf-8 back end
// an accepted item is held in the action queue, which absorbs bursts, and then in the
// back end's output register; throughput: one byte per cycle while not full, and a \u
// escape drains 1 to 4 bytes, one per cycle while pop is held, set by that register
// reset: asynchronous active low; queues empty, parser idle until new_string is set
module json_string_unescape #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       new_string_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic [2:0] outcome_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic          accept;
  logic          act_valid;
  action_t       act, head;
  queue_status_t q_status;
  logic          head_pop;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .new_string_i(new_string_i),
    .act_valid_o (act_valid),
    .act_o       (act)
  );

  jsu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (act_valid),
    .item_i  (act),
    .pop_i   (head_pop),
    .item_o  (head),
    .status_o(q_status)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_status.empty),
    .head_i      (head),
    .head_pop_o  (head_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .data_byte_o (data_byte_o),
    .outcome_o   (outcome_o),
    .last_o      (last_o)
  );

  // a done or error result is always the item's only and final result
  a_code_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && outcome_o != OUT_BYTE) |-> last_o)
    else $error("done or error result not marked last");

  a_code_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && outcome_o != OUT_BYTE) |-> (data_byte_o == 8'h00))
    else $error("done or error result carries data");

  a_outcome_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outcome_o <= OUT_END))
    else $error("outcome code out of range");

  // the back end never pops an empty action queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> !q_status.empty)
    else $error("action queue popped while empty");

endmodule

// File: design/jsu_front.sv
// front part: parses string body bytes and classifies each item into one action
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      text_byte_i,
  input  logic            new_string_i,
  output logic            act_valid_o,
  output jsu_pkg::action_t act_o
);
  import jsu_pkg::*;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  held_q, held_d;
  logic        fin_q, fin_d;

  mode_e       cur_mode;
  logic [15:0] cur_acc;
  logic [9:0]  cur_held;
  logic        cur_fin;
  logic [4:0]  hex;         // bit 4 set means not a hex digit
  logic [15:0] acc_new;
  logic        is_low;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  assign cur_mode = new_string_i ? MODE_NORMAL : mode_q;
  assign cur_acc  = new_string_i ? 16'h0 : acc_q;
  assign cur_held = new_string_i ? 10'h0 : held_q;
  assign cur_fin  = new_string_i ? 1'b0 : fin_q;
  assign hex      = hex_digit(text_byte_i);
  assign acc_new  = {cur_acc[11:0], hex[3:0]};
  assign is_low   = (acc_new[15:10] == 6'b110111);

  always_comb begin
    mode_d      = cur_mode;
    acc_d       = cur_acc;
    held_d      = cur_held;
    fin_d       = cur_fin;
    act_valid_o = 1'b0;
    act_o       = '{is_cp: 1'b0, value: '0, outcome: OUT_BYTE};
    if (!cur_fin) begin
      if (text_byte_i == 8'h00) begin
        act_valid_o   = 1'b1;
        act_o.outcome = OUT_END;
        fin_d         = 1'b1;
        mode_d        = MODE_NORMAL;
      end else begin
        case (cur_mode)
          MODE_ESC: begin
            mode_d      = MODE_NORMAL;
            act_valid_o = 1'b1;
            case (text_byte_i)
              ChQuote, ChBslash, ChSlash: act_o.value = {13'h0, text_byte_i};
              8'h62: act_o.value = {13'h0, 8'h08};
              8'h66: act_o.value = {13'h0, 8'h0C};
              8'h6E: act_o.value = {13'h0, 8'h0A};
              8'h72: act_o.value = {13'h0, 8'h0D};
              8'h74: act_o.value = {13'h0, 8'h09};
              ChU: begin
                act_valid_o = 1'b0;
                acc_d       = 16'h0;
                mode_d      = MODE_HEX1;
              end
              default: begin
                act_o.outcome = OUT_BAD_ESC;
                fin_d         = 1'b1;
              end
            endcase
          end
          MODE_PAIR_BS: begin
            if (text_byte_i == ChBslash) begin
              mode_d = MODE_PAIR_U;
            end else begin
              act_valid_o   = 1'b1;
              act_o.outcome = OUT_BAD_SURR;
              fin_d         = 1'b1;
              mode_d        = MODE_NORMAL;
            end
          end
          MODE_PAIR_U: begin
            if (text_byte_i == ChU) begin
              acc_d  = 16'h0;
              mode_d = MODE_LOW1;
            end else begin
              act_valid_o   = 1'b1;
              act_o.outcome = OUT_BAD_SURR;
              fin_d         = 1'b1;
              mode_d        = MODE_NORMAL;
            end
          end
          MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4,
          MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
            if (hex[4]) begin
              act_valid_o   = 1'b1;
              act_o.outcome = OUT_BAD_HEX;
              fin_d         = 1'b1;
              mode_d        = MODE_NORMAL;
            end else begin
              acc_d = acc_new;
              case (cur_mode)
                MODE_HEX1: mode_d = MODE_HEX2;
                MODE_HEX2: mode_d = MODE_HEX3;
                MODE_HEX3: mode_d = MODE_HEX4;
                MODE_LOW1: mode_d = MODE_LOW2;
                MODE_LOW2: mode_d = MODE_LOW3;
                MODE_LOW3: mode_d = MODE_LOW4;
                MODE_HEX4: begin
                  if (acc_new[15:10] == 6'b110110) begin
                    held_d = acc_new[9:0];
                    mode_d = MODE_PAIR_BS;
                  end else if (is_low) begin
                    act_valid_o   = 1'b1;
                    act_o.outcome = OUT_BAD_SURR;
                    fin_d         = 1'b1;
                    mode_d        = MODE_NORMAL;
                  end else begin
                    act_valid_o = 1'b1;
                    act_o.is_cp = 1'b1;
                    act_o.value = {5'h0, acc_new};
                    mode_d      = MODE_NORMAL;
                  end
                end
                default: begin
                  // last digit of the low half
                  act_valid_o = 1'b1;
                  mode_d      = MODE_NORMAL;
                  if (is_low) begin
                    act_o.is_cp = 1'b1;
                    act_o.value = {1'b0, cur_held, acc_new[9:0]} + 21'h10000;
                  end else begin
                    act_o.outcome = OUT_BAD_SURR;
                    fin_d         = 1'b1;
                  end
                end
              endcase
            end
          end
          default: begin
            // normal character mode
            mode_d = MODE_NORMAL;
            if (text_byte_i == ChQuote) begin
              act_valid_o   = 1'b1;
              act_o.outcome = OUT_DONE;
              fin_d         = 1'b1;
            end else if (text_byte_i == ChBslash) begin
              mode_d = MODE_ESC;
            end else begin
              act_valid_o = 1'b1;
              act_o.value = {13'h0, text_byte_i};
            end
          end
        endcase
      end
    end
    if (!accept_i) act_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= 16'h0;
      held_q <= 10'h0;
      fin_q  <= 1'b1;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      held_q <= held_d;
      fin_q  <= fin_d;
    end
  end

endmodule

// File: design/jsu_queue.sv
// short action queue between the front and back parts
module jsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  jsu_pkg::action_t       item_i,
  input  logic                   pop_i,
  output jsu_pkg::action_t       item_o,
  output jsu_pkg::queue_status_t status_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  action_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/jsu_back.sv
// back part: expands actions into result bytes, utf-8 encoding code points
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  jsu_pkg::action_t head_i,
  output logic             head_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       outcome_o,
  output logic             last_o
);
  import jsu_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         data_q, data_d;
  logic [2:0]         outcome_q, outcome_d;
  logic               last_q, last_d;
  logic [CpWidth-1:0] cp;
  logic [1:0]         n_m1;     // result count minus one
  logic [7:0]         byte_sel;
  logic               load, final_byte;

  assign cp = head_i.value;

  always_comb begin
    n_m1 = 2'd0;
    if (head_i.is_cp) begin
      if (cp < 21'h80) n_m1 = 2'd0;
      else if (cp < 21'h800) n_m1 = 2'd1;
      else if (cp < 21'h10000) n_m1 = 2'd2;
      else n_m1 = 2'd3;
    end
  end

  always_comb begin
    byte_sel = cp[7:0];
    case (n_m1)
      2'd1: begin
        case (idx_q)
          2'd0:    byte_sel = {3'b110, cp[10:6]};
          default: byte_sel = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx_q)
          2'd0:    byte_sel = {4'b1110, cp[15:12]};
          2'd1:    byte_sel = {2'b10, cp[11:6]};
          default: byte_sel = {2'b10, cp[5:0]};
        endcase
      end
      2'd3: begin
        case (idx_q)
          2'd0:    byte_sel = {5'b11110, cp[20:18]};
          2'd1:    byte_sel = {2'b10, cp[17:12]};
          2'd2:    byte_sel = {2'b10, cp[11:6]};
          default: byte_sel = {2'b10, cp[5:0]};
        endcase
      end
      default: byte_sel = cp[7:0];
    endcase
  end

  // output register reloads when empty or being drained
  assign load       = head_valid_i && (!out_valid_q || pop_i);
  assign final_byte = (idx_q == n_m1);
  assign head_pop_o = load && final_byte;

  always_comb begin
    out_valid_d = out_valid_q;
    data_d      = data_q;
    outcome_d   = outcome_q;
    last_d      = last_q;
    idx_d       = idx_q;
    if (out_valid_q && pop_i) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      data_d      = byte_sel;
      outcome_d   = head_i.outcome;
      last_d      = final_byte;
      idx_d       = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    outcome_q <= outcome_d;
    last_q    <= last_d;
  end

  assign empty_o     = !out_valid_q;
  assign data_byte_o = data_q;
  assign outcome_o   = outcome_q;
  assign last_o      = last_q;

endmodule
